FILE: rtl/llg_pkg.sv
// Shared constants, opcodes and nonlinearity tables for the logistic loss oracle.
package llg_pkg;

  localparam int DIM_DEFAULT         = 1024;
  localparam int VALUE_WIDTH_DEFAULT = 16;

  localparam int INDEX_W  = 10;
  localparam int ACC_W    = 48;
  localparam int MARGIN_W = 24;
  localparam int GRAD_W   = 18;
  localparam int TERM_W   = 31;
  localparam int SUM_W    = 47;
  localparam int COUNT_W  = 32;
  localparam int TAB_W    = 17;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_FEATURE = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [TAB_W-1:0] ONE_Q16 = 17'd65536;

  function automatic logic [TAB_W-1:0] sig_at(input logic [4:0] i);
    logic [TAB_W-1:0] r;
    unique case (i)
      5'd0:  r = 17'd32768;
      5'd1:  r = 17'd40793;
      5'd2:  r = 17'd47911;
      5'd3:  r = 17'd53581;
      5'd4:  r = 17'd57724;
      5'd5:  r = 17'd60565;
      5'd6:  r = 17'd62428;
      5'd7:  r = 17'd63615;
      5'd8:  r = 17'd64357;
      5'd9:  r = 17'd64816;
      5'd10: r = 17'd65097;
      5'd11: r = 17'd65269;
      5'd12: r = 17'd65374;
      5'd13: r = 17'd65438;
      5'd14: r = 17'd65476;
      5'd15: r = 17'd65500;
      5'd16: r = 17'd65514;
      default: r = ONE_Q16;
    endcase
    return r;
  endfunction

  function automatic logic [TAB_W-1:0] spl_at(input logic [4:0] i);
    logic [TAB_W-1:0] r;
    unique case (i)
      5'd0:  r = 17'd45426;
      5'd1:  r = 17'd31069;
      5'd2:  r = 17'd20530;
      5'd3:  r = 17'd13200;
      5'd4:  r = 17'd8318;
      5'd5:  r = 17'd5170;
      5'd6:  r = 17'd3184;
      5'd7:  r = 17'd1950;
      5'd8:  r = 17'd1189;
      5'd9:  r = 17'd724;
      5'd10: r = 17'd440;
      5'd11: r = 17'd267;
      5'd12: r = 17'd162;
      5'd13: r = 17'd98;
      5'd14: r = 17'd60;
      5'd15: r = 17'd36;
      5'd16: r = 17'd22;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/llg_if.sv
// Valid/ready channel interfaces for the oracle's input and result words.
interface llg_in_if #(
  parameter int VALUE_WIDTH = llg_pkg::VALUE_WIDTH_DEFAULT
);
  logic                                valid;
  logic                                ready;
  logic [1:0]                          opcode;
  logic [llg_pkg::INDEX_W-1:0]         feature_index;
  logic signed [VALUE_WIDTH-1:0]       value;
  logic                                label_positive;
  logic                                last_of_sample;

  modport source (output valid, opcode, feature_index, value, label_positive,
                  last_of_sample, input ready);
  modport sink (input valid, opcode, feature_index, value, label_positive,
                last_of_sample, output ready);
endinterface

interface llg_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [llg_pkg::GRAD_W-1:0]   grad_coef;
  logic [llg_pkg::TERM_W-1:0]          loss_term;
  logic [llg_pkg::SUM_W-1:0]           loss_sum;
  logic [llg_pkg::COUNT_W-1:0]         sample_count;

  modport source (output valid, grad_coef, loss_term, loss_sum, sample_count,
                  input ready);
  modport sink (input valid, grad_coef, loss_term, loss_sum, sample_count,
                output ready);
endinterface

FILE: rtl/logistic_loss_gradient_oracle_unit.sv
// Logistic regression loss/gradient oracle: weight RAM, shared multiplier, sequencer.
// Weight writes and clears complete in the idle state. A feature element passes
// through weight read, multiply and accumulate; an element marked last then adds
// margin, two table interpolations through the same multiplier, and result load,
// which waits for the result channel. One 17x17 multiplier carries every product.
// Reset clears the dot accumulator, loss sum, sample count and output valid;
// weight RAM contents are undefined until written.
module logistic_loss_gradient_oracle_unit #(
  parameter int DIM         = llg_pkg::DIM_DEFAULT,
  parameter int VALUE_WIDTH = llg_pkg::VALUE_WIDTH_DEFAULT
) (
  input logic clk,
  input logic rst,
  llg_in_if.sink   feed,
  llg_out_if.source result
);
  import llg_pkg::*;

  localparam int AW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int MW = (VALUE_WIDTH > TAB_W) ? VALUE_WIDTH : TAB_W;
  localparam int PW = 2 * MW;
  localparam int SW = ((PW > ACC_W) ? PW : ACC_W) + 1;

  localparam logic signed [SW-1:0] ACC_MAX_S = SW'({1'b0, {(ACC_W-1){1'b1}}});
  localparam logic signed [SW-1:0] ACC_MIN_S = -ACC_MAX_S - SW'(1);

  typedef enum logic [2:0] {
    S_IDLE, S_MAC, S_ACC, S_MARG, S_SIGM, S_SPLM, S_FIN
  } state_t;

  state_t state;
  logic signed [VALUE_WIDTH-1:0] val_reg;
  logic                          last_reg;
  logic                          ypos_reg;
  logic                          zero_w;
  logic signed [ACC_W-1:0]       acc;
  logic                          mneg;
  logic [MARGIN_W-1:0]           a_reg;
  logic signed [PW-1:0]          prod;
  logic [TAB_W-1:0]              sig_val;
  logic [SUM_W-1:0]              loss_sum;
  logic [COUNT_W-1:0]            count;

  logic [VALUE_WIDTH-1:0] rdata;
  logic                   accept;
  logic                   idx_ok;
  logic signed [MW-1:0]   mul_a;
  logic signed [MW-1:0]   mul_b;

  logic                   big;
  logic [4:0]             seg;
  logic [TAB_W-1:0]       sig_lo;
  logic [TAB_W-1:0]       sig_hi;
  logic [TAB_W-1:0]       spl_lo;
  logic [TAB_W-1:0]       spl_hi;
  logic [TAB_W-1:0]       interp;

  logic signed [SW-1:0]       acc_sum;
  logic signed [ACC_W:0]      x;
  logic signed [ACC_W-8:0]    sh;
  logic signed [MARGIN_W-1:0] m_sat;

  logic [TAB_W-1:0]       spl_val;
  logic [TAB_W-1:0]       sig_m;
  logic [TERM_W-1:0]      term;
  logic signed [GRAD_W-1:0] grad;
  logic [SUM_W:0]         sum_next;
  logic [SUM_W-1:0]       loss_sum_next;
  logic [COUNT_W-1:0]     count_next;

  assign feed.ready = (state == S_IDLE);
  assign accept     = feed.valid && feed.ready;
  assign idx_ok     = (32'(feed.feature_index) < 32'(DIM));

  llg_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DIM)) u_wram (
    .clk   (clk),
    .we    (accept && feed.opcode == OP_WRITE && idx_ok),
    .waddr (AW'(feed.feature_index)),
    .wdata (feed.value),
    .raddr (AW'(feed.feature_index)),
    .rdata (rdata)
  );

  // Table lookup on the registered magnitude of the margin.
  assign big    = (a_reg[MARGIN_W-1:19] != '0);
  assign seg    = {1'b0, a_reg[18:15]};
  assign sig_lo = sig_at(seg);
  assign sig_hi = sig_at(seg + 5'd1);
  assign spl_lo = spl_at(seg);
  assign spl_hi = spl_at(seg + 5'd1);
  assign interp = TAB_W'(prod >>> 15);

  // The one multiplier: weight times feature, then table step times fraction.
  // The softplus product is held through the final step while the result waits.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MAC: begin
        mul_a = zero_w ? '0 : MW'($signed(rdata));
        mul_b = MW'(val_reg);
      end
      S_SIGM: begin
        mul_a = MW'($signed({1'b0, sig_hi - sig_lo}));
        mul_b = MW'($signed({1'b0, a_reg[14:0]}));
      end
      S_SPLM, S_FIN: begin
        mul_a = MW'($signed({1'b0, spl_lo - spl_hi}));
        mul_b = MW'($signed({1'b0, a_reg[14:0]}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    acc_sum = SW'(acc) + SW'(prod);
    x       = ypos_reg ? -(ACC_W+1)'(acc) : (ACC_W+1)'(acc);
    sh      = (ACC_W-7)'(x >>> 8);
    if (sh > (ACC_W-7)'(2**(MARGIN_W-1) - 1)) begin
      m_sat = {1'b0, {(MARGIN_W-1){1'b1}}};
    end else if (sh < -(ACC_W-7)'(2**(MARGIN_W-1))) begin
      m_sat = {1'b1, {(MARGIN_W-1){1'b0}}};
    end else begin
      m_sat = MARGIN_W'(sh);
    end

    spl_val  = big ? '0 : spl_lo - interp;
    sig_m    = mneg ? ONE_Q16 - sig_val : sig_val;
    term     = mneg ? TERM_W'(spl_val) : TERM_W'(a_reg) + TERM_W'(spl_val);
    grad     = ypos_reg ? -GRAD_W'(sig_m) : GRAD_W'(sig_m);
    sum_next = (SUM_W+1)'(loss_sum) + (SUM_W+1)'(term);
    loss_sum_next = sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
    count_next    = (count == '1) ? count : count + COUNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      acc          <= '0;
      loss_sum     <= '0;
      count        <= '0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != S_FIN) begin
        result.valid <= 1'b0;
      end
      prod <= mul_a * mul_b;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            val_reg  <= feed.value;
            last_reg <= feed.last_of_sample;
            ypos_reg <= feed.label_positive;
            zero_w   <= !idx_ok;
            case (feed.opcode)
              OP_FEATURE: state <= S_MAC;
              OP_CLEAR: begin
                loss_sum <= '0;
                count    <= '0;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_MAC: state <= S_ACC;
        S_ACC: begin
          if (acc_sum > ACC_MAX_S) begin
            acc <= ACC_MAX_S[ACC_W-1:0];
          end else if (acc_sum < ACC_MIN_S) begin
            acc <= ACC_MIN_S[ACC_W-1:0];
          end else begin
            acc <= ACC_W'(acc_sum);
          end
          state <= last_reg ? S_MARG : S_IDLE;
        end
        S_MARG: begin
          mneg  <= m_sat[MARGIN_W-1];
          a_reg <= m_sat[MARGIN_W-1] ? MARGIN_W'(-(MARGIN_W+1)'(m_sat)) : MARGIN_W'(m_sat);
          acc   <= '0;
          state <= S_SIGM;
        end
        S_SIGM: state <= S_SPLM;
        S_SPLM: begin
          sig_val <= big ? ONE_Q16 : sig_lo + interp;
          state   <= S_FIN;
        end
        S_FIN: begin
          if (!result.valid || result.ready) begin
            result.valid        <= 1'b1;
            result.grad_coef    <= grad;
            result.loss_term    <= term;
            result.loss_sum     <= loss_sum_next;
            result.sample_count <= count_next;
            loss_sum            <= loss_sum_next;
            count               <= count_next;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_feature_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && feed.opcode == OP_FEATURE) |=> !feed.ready)
    else $error("ready stayed high after a feature word");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == S_FIN))
    else $error("result raised outside the final step");

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> (acc == '0))
    else $error("dot accumulator not cleared after a sample");

  a_grad_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.grad_coef <= GRAD_W'(65536) &&
                      result.grad_coef >= -GRAD_W'(65536)))
    else $error("gradient coefficient out of range");
`endif

endmodule

FILE: rtl/llg_ram.sv
// Single-port-write, registered-read generic RAM.
module llg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
